// ===== src/ps2md_pkg.sv =====
// Shared constants and the acceleration helper function for the PS/2 mouse packet decoder.
package ps2md_pkg;

  localparam int ByteW   = 8;
  localparam int ButW    = 3;
  localparam int DxW     = 11;
  localparam int DyW     = 12;
  localparam int WheelW  = 8;
  localparam int IdxW    = 2;
  localparam int MotionW = 10;  // 9-bit motion plus room for negation

  // Header bit positions
  localparam int HdrLeft   = 0;
  localparam int HdrRight  = 1;
  localparam int HdrMiddle = 2;
  localparam int HdrXSign  = 4;
  localparam int HdrYSign  = 5;

  // Byte positions within a packet
  localparam logic [IdxW-1:0] PosHdr   = 2'd0;
  localparam logic [IdxW-1:0] PosX     = 2'd1;
  localparam logic [IdxW-1:0] PosY     = 2'd2;
  localparam logic [IdxW-1:0] PosWheel = 2'd3;

  // Motion magnitude above which acceleration applies
  localparam logic signed [MotionW-1:0] AccelLimit = 10'sd5;

  // Multiply motion by 4 when its magnitude exceeds the limit
  function automatic logic signed [DyW-1:0] accel(input logic signed [MotionW-1:0] v);
    logic signed [DyW-1:0] ext;
    ext = DyW'(v);
    if ((v > AccelLimit) || (v < -AccelLimit)) begin
      accel = ext <<< 2;
    end else begin
      accel = ext;
    end
  endfunction

endpackage

// ===== src/ps2_mouse_packet_decoder.sv =====
// PS/2 mouse packet decoder: byte collection, field decode and result register.
//
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) carries one byte per beat
//   as received from the mouse port. Bytes are grouped into packets of three
//   (header, X, Y), or four with a trailing wheel byte when wheel mode is set.
//   Result channel (out_valid / out_stall / out_* fields) carries one beat per
//   complete packet: remapped buttons, accelerated X and negated, accelerated Y
//   motion, and the signed wheel motion (zero without wheel mode).
//   Configuration channel (cfg_valid / cfg_ready / cfg_wheel_mode) writes the
//   wheel mode bit; it is always ready and should be written while idle.
// Timing:
//   The byte that completes a packet is decoded in the cycle it is accepted and
//   the result appears on the output register in the next cycle. One byte is
//   accepted every cycle while not stalled; the single output register sets it.
// Reset:
//   Synchronous rst_n clears the byte position, the stored packet bytes, the
//   wheel mode bit and the output valid.
// Backpressure:
//   While a result waits under out_stall, in_stall is raised and no byte is taken.
module ps2_mouse_packet_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ps2md_pkg::ByteW-1:0]         in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ps2md_pkg::ButW-1:0]          out_buttons,
  output logic signed [ps2md_pkg::DxW-1:0]    out_delta_x,
  output logic signed [ps2md_pkg::DyW-1:0]    out_delta_y,
  output logic signed [ps2md_pkg::WheelW-1:0] out_delta_wheel,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_wheel_mode
);
  import ps2md_pkg::*;

  logic                     wheel_mode_r;
  logic [IdxW-1:0]          byte_index_r, byte_index_nxt;
  logic [ByteW-1:0]         pkt_r [3];
  logic                     out_valid_r, out_valid_nxt;
  logic [ButW-1:0]          buttons_r;
  logic signed [DxW-1:0]    delta_x_r;
  logic signed [DyW-1:0]    delta_y_r;
  logic signed [WheelW-1:0] delta_wheel_r;

  logic                     accept;
  logic                     complete;
  logic [ByteW-1:0]         hdr;
  logic [ByteW-1:0]         y_byte;
  logic signed [MotionW-1:0] dx_raw, dy_raw;
  logic [ButW-1:0]          buttons_nxt;
  logic signed [DxW-1:0]    delta_x_nxt;
  logic signed [DyW-1:0]    delta_y_nxt;
  logic signed [WheelW-1:0] delta_wheel_nxt;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;

  // Packet completes on the last byte for the current mode
  assign complete = wheel_mode_r ? (byte_index_r == PosWheel)
                                 : (byte_index_r >= PosY);

  // Decode the packet, bypassing the Y byte when it arrives now
  always_comb begin
    hdr             = pkt_r[PosHdr];
    y_byte          = (byte_index_r == PosY) ? in_rx_byte : pkt_r[PosY];
    buttons_nxt     = {hdr[HdrLeft], hdr[HdrMiddle], hdr[HdrRight]};
    dx_raw          = {hdr[HdrXSign], hdr[HdrXSign], pkt_r[PosX]};
    dy_raw          = -$signed({hdr[HdrYSign], hdr[HdrYSign], y_byte});
    delta_x_nxt     = DxW'(accel(dx_raw));
    delta_y_nxt     = accel(dy_raw);
    delta_wheel_nxt = (wheel_mode_r && (byte_index_r == PosWheel))
                      ? $signed(in_rx_byte) : '0;
  end

  // Advance the byte position
  always_comb begin
    byte_index_nxt = byte_index_r;
    if (accept) begin
      byte_index_nxt = complete ? PosHdr : byte_index_r + 2'd1;
    end
  end

  // Output valid: set on a completed packet, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept && complete) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state and stored packet bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_mode_r <= 1'b0;
      byte_index_r <= PosHdr;
      out_valid_r  <= 1'b0;
      pkt_r[0]     <= '0;
      pkt_r[1]     <= '0;
      pkt_r[2]     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        wheel_mode_r <= cfg_wheel_mode;
      end
      byte_index_r <= byte_index_nxt;
      out_valid_r  <= out_valid_nxt;
      if (accept && (byte_index_r != PosWheel)) begin
        pkt_r[byte_index_r] <= in_rx_byte;
      end
    end
  end

  // Result register: load on a completed packet
  always_ff @(posedge clk) begin
    if (accept && complete) begin
      buttons_r     <= buttons_nxt;
      delta_x_r     <= delta_x_nxt;
      delta_y_r     <= delta_y_nxt;
      delta_wheel_r <= delta_wheel_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_buttons     = buttons_r;
  assign out_delta_x     = delta_x_r;
  assign out_delta_y     = delta_y_r;
  assign out_delta_wheel = delta_wheel_r;

endmodule

// ===== sim/ps2_mouse_packet_decoder_test.sv =====
// Self-checking testbench for the PS/2 mouse packet decoder with wheel byte.
`timescale 1ns / 100ps

module ps2_mouse_packet_decoder_test;
  import ps2md_pkg::*;

  typedef struct {
    logic [ButW-1:0]          buttons;
    logic signed [DxW-1:0]    delta_x;
    logic signed [DyW-1:0]    delta_y;
    logic signed [WheelW-1:0] delta_wheel;
  } motion_report_t;

  localparam int HoldCycles    = 200;
  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles  = 4;
  localparam int RandomPhases  = 8;
  localparam int PhaseBytes    = 150;
  localparam int MaxIdle       = 8;
  localparam int BoostAbove    = 5;
  localparam int BoostGain     = 4;
  localparam int NinthBit      = 256;

  // Three-byte packets: button, sign and boost corners, then two bytes of a
  // packet left open for the switch into wheel mode
  localparam logic [ByteW-1:0] PlainBytes [23] = '{
    8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF,
    8'h11, 8'h00, 8'hFF,
    8'h22, 8'hFF, 8'h00,
    8'h0C, 8'h05, 8'h06,
    8'h30, 8'hFB, 8'hFA,
    8'hC0, 8'h06, 8'h05,
    8'h04, 8'h7F
  };

  // Wheel packets: finish the open packet, wheel extremes, then stop at the
  // wheel position so that clearing the mode completes it without a wheel
  localparam logic [ByteW-1:0] WheelBytes [13] = '{
    8'h80, 8'h01,
    8'h08, 8'h01, 8'h02, 8'h80,
    8'h08, 8'hFA, 8'h06, 8'h7F,
    8'h0F, 8'h10, 8'hF0
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [ByteW-1:0]         in_rx_byte = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [ButW-1:0]          out_buttons;
  logic signed [DxW-1:0]    out_delta_x;
  logic signed [DyW-1:0]    out_delta_y;
  logic signed [WheelW-1:0] out_delta_wheel;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic                     cfg_wheel_mode = 1'b0;

  // Pending bytes and decoded packets still owed by the block
  logic [ByteW-1:0] tx_bytes[$];
  motion_report_t   motion_reports[$];
  motion_report_t   want;

  // Packet assembly mirror
  logic             wheel_on = 1'b0;
  logic [IdxW-1:0]  next_pos = PosHdr;
  logic [ByteW-1:0] held_bytes [3];

  int src_gap_max = 0;
  int sink_stall_max = 0;
  int src_gap = 0;
  int sink_stall = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  ps2_mouse_packet_decoder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_buttons    (out_buttons),
    .out_delta_x    (out_delta_x),
    .out_delta_y    (out_delta_y),
    .out_delta_wheel(out_delta_wheel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_wheel_mode (cfg_wheel_mode)
  );

  always #5 clk = ~clk;

  function automatic int boost(input int v);
    return (v > BoostAbove || v < -BoostAbove) ? v * BoostGain : v;
  endfunction

  // Absorb one accepted byte; queue the decoded report when it closes a packet
  function automatic void decode_mouse_byte(input logic [ByteW-1:0] rx);
    logic [IdxW-1:0]  pos;
    logic [ByteW-1:0] hdr;
    int               x;
    int               y;
    motion_report_t   rep;
    pos = next_pos;
    if (pos != PosWheel) held_bytes[pos] = rx;
    if (pos < (wheel_on ? PosWheel : PosY)) begin
      next_pos = pos + 1'b1;
      return;
    end
    next_pos = PosHdr;
    hdr = held_bytes[PosHdr];
    x = int'(held_bytes[PosX]) - (hdr[HdrXSign] ? NinthBit : 0);
    y = (hdr[HdrYSign] ? NinthBit : 0) - int'(held_bytes[PosY]);
    rep.buttons     = {hdr[HdrLeft], hdr[HdrMiddle], hdr[HdrRight]};
    rep.delta_x     = DxW'(boost(x));
    rep.delta_y     = DyW'(boost(y));
    rep.delta_wheel = (wheel_on && pos == PosWheel) ? $signed(rx) : '0;
    motion_reports.push_back(rep);
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] exp_v,
                                      input logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // Motion bytes lean toward the boost threshold on both sides of zero
  function automatic logic [ByteW-1:0] motion_byte();
    case ($urandom_range(0, 3))
      0: return ByteW'($urandom_range(0, 7));
      1: return ByteW'(NinthBit - $urandom_range(1, 8));
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  // Driver: offer queued bytes with random gaps, predict on every accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
      next_pos = PosHdr;
      foreach (held_bytes[i]) held_bytes[i] = '0;
    end else begin
      if (in_valid && !in_stall) decode_mouse_byte(in_rx_byte);
      if (!in_valid || !in_stall) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          in_rx_byte <= tx_bytes.pop_front();
          in_valid <= 1'b1;
          src_gap = $urandom_range(0, src_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result beat, then draw the stall before the next
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_stall = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (motion_reports.size() == 0) begin
          $error("unexpected result: buttons %0d x %0d y %0d wheel %0d",
                 out_buttons, out_delta_x, out_delta_y, out_delta_wheel);
          mismatches++;
        end else begin
          want = motion_reports.pop_front();
          check_field("buttons", want.buttons, out_buttons);
          check_field("delta_x", want.delta_x, out_delta_x);
          check_field("delta_y", want.delta_y, out_delta_y);
          check_field("delta_wheel", want.delta_wheel, out_delta_wheel);
        end
        sink_stall = $urandom_range(0, sink_stall_max);
      end
      // Start a long hold when requested, so the input side backs up
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (sink_stall > 0) begin
        sink_stall--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: stop the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Wait until every byte is taken and every report has come back
  task automatic await_idle();
    do @(negedge clk);
    while (tx_bytes.size() != 0 || in_valid || motion_reports.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_wheel_mode(input logic mode);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_wheel_mode <= mode;
    do @(posedge clk);
    while (!cfg_ready);
    wheel_on = mode;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int extra;
    logic mode;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed three-byte packets
    write_wheel_mode(1'b0);
    @(negedge clk);
    src_gap_max = $urandom_range(0, MaxIdle);
    sink_stall_max = $urandom_range(0, MaxIdle);
    foreach (PlainBytes[i]) tx_bytes.push_back(PlainBytes[i]);
    await_idle();

    // Directed wheel packets, entered with a packet half done
    write_wheel_mode(1'b1);
    @(negedge clk);
    foreach (WheelBytes[i]) tx_bytes.push_back(WheelBytes[i]);
    await_idle();

    // Random phases; the first one clears wheel mode on an open wheel slot
    for (int p = 0; p < RandomPhases; p++) begin
      mode = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      write_wheel_mode(mode);
      @(negedge clk);
      case (p % 4)
        0: begin
          src_gap_max = 0;
          sink_stall_max = 0;
        end
        1: begin
          src_gap_max = MaxIdle;
          sink_stall_max = MaxIdle;
        end
        default: begin
          src_gap_max = $urandom_range(0, MaxIdle);
          sink_stall_max = $urandom_range(0, MaxIdle);
        end
      endcase
      extra = $urandom_range(0, 3);
      for (int k = 0; k < PhaseBytes + extra; k++) begin
        tx_bytes.push_back((k % (mode ? 4 : 3) == 0) ? ByteW'($urandom_range(0, 255))
                                                     : motion_byte());
      end
      // Hold the result side off while the sender keeps offering
      if (p == 2) begin
        src_gap_max = 0;
        hold_req++;
      end
      await_idle();
    end

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ps2md_pkg.sv
src/ps2_mouse_packet_decoder.sv
sim/ps2_mouse_packet_decoder_test.sv
